FILE: src/mcfr_pkg.sv
`timescale 1ns / 1ps

package mcfr_pkg;

    // frame layout
    localparam int unsigned FRAME_LEN = 13;
    localparam logic [3:0]  LEN_FULL  = 4'd13;
    localparam logic [3:0]  COUNT_SAT = 4'd14;
    localparam logic [3:0]  SUM_FIRST = 4'd1;
    localparam logic [3:0]  SUM_LAST  = 4'd8;

    localparam logic [7:0] HDR0 = 8'h4F;
    localparam logic [7:0] HDR1 = 8'h2A;
    localparam logic [7:0] TRL0 = 8'h0D;
    localparam logic [7:0] TRL1 = 8'h0A;

    localparam logic [7:0] ECHO_RESET = 8'd240;

    // frame status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_LEN  = 3'd1;
    localparam logic [2:0] ST_BAD_WRAP = 3'd2;
    localparam logic [2:0] ST_BAD_SUM  = 3'd3;
    localparam logic [2:0] ST_BAD_ECHO = 3'd4;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } item_t;

    typedef struct packed {
        logic [2:0]  frame_status;
        logic        brake_on;
        logic        motor_running;
        logic [4:0]  fault_flags;
        logic        ecu_enabled;
        logic        motor_locked;
        logic [2:0]  speed_limit_step;
        logic [1:0]  assist_mode;
        logic [15:0] hall_changes;
        logic [4:0]  alarms_raised;
        logic [4:0]  alarms_cleared;
    } result_t;

endpackage

FILE: src/motor_controller_frame_receiver.sv
`timescale 1ns / 1ps

// Receives the motor controller's 13-byte reply frame one byte per transfer
// and gives one result for every byte marked with frame_end. A byte goes into
// an input register, from there the frame checker folds it into the running
// count, checksum and byte store and judges the frame, and the verdict lands
// in the output register, flagged by out_valid. Throughput is one byte per
// clock while no closing byte waits. The only stall comes from the output
// side: a closing byte waits in the input register while an earlier result
// has not been taken, and in_ready stays low until that result transfers.
// Non-ok results carry only frame_status. The user must write expected_echo
// through cfg_wr_en/cfg_wr_data only while idle; the block does not enforce it.
module motor_controller_frame_receiver
(
    input  logic        clk,
    input  logic        rst_n,

    // byte input
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        frame_end,

    // expected echo register
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,

    // frame result
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  frame_status,
    output logic        brake_on,
    output logic        motor_running,
    output logic [4:0]  fault_flags,
    output logic        ecu_enabled,
    output logic        motor_locked,
    output logic [2:0]  speed_limit_step,
    output logic [1:0]  assist_mode,
    output logic [15:0] hall_changes,
    output logic [4:0]  alarms_raised,
    output logic [4:0]  alarms_cleared
);

    logic              held_valid;
    mcfr_pkg::item_t   held_item;
    mcfr_pkg::item_t   in_item;
    mcfr_pkg::result_t check_result;
    logic              advance;

    logic              out_valid_reg;
    logic              out_valid_next;
    mcfr_pkg::result_t result_reg;
    logic [7:0]        echo_reg;

    assign in_item.rx_byte   = rx_byte;
    assign in_item.frame_end = frame_end;

    // a held data byte always moves on; a closing byte needs a free result slot
    assign advance = held_valid && (!held_item.frame_end || !out_valid_reg || out_ready);

    mcfr_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    mcfr_frame_check u_frame_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .item          (held_item),
        .expected_echo (echo_reg),
        .result        (check_result)
    );

    // result register: loads on a judged frame, empties on an output transfer
    always_comb
    begin
        if (advance && held_item.frame_end)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            echo_reg      <= mcfr_pkg::ECHO_RESET;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                echo_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && held_item.frame_end)
        begin
            result_reg <= check_result;
        end
    end

    assign out_valid        = out_valid_reg;
    assign frame_status     = result_reg.frame_status;
    assign brake_on         = result_reg.brake_on;
    assign motor_running    = result_reg.motor_running;
    assign fault_flags      = result_reg.fault_flags;
    assign ecu_enabled      = result_reg.ecu_enabled;
    assign motor_locked     = result_reg.motor_locked;
    assign speed_limit_step = result_reg.speed_limit_step;
    assign assist_mode      = result_reg.assist_mode;
    assign hall_changes     = result_reg.hall_changes;
    assign alarms_raised    = result_reg.alarms_raised;
    assign alarms_cleared   = result_reg.alarms_cleared;

endmodule

FILE: src/mcfr_in_stage.sv
`timescale 1ns / 1ps

module mcfr_in_stage
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  mcfr_pkg::item_t in_item,
    input  logic           advance,
    output logic           held_valid,
    output mcfr_pkg::item_t held_item
);

    logic            valid_reg;
    logic            valid_next;
    mcfr_pkg::item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_valid ? 1'b1 : (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload register, loaded on every input transfer
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

FILE: src/mcfr_frame_check.sv
`timescale 1ns / 1ps

module mcfr_frame_check
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  mcfr_pkg::item_t   item,
    input  logic [7:0]        expected_echo,
    output mcfr_pkg::result_t result
);

    logic [3:0]  count_reg;
    logic [3:0]  count_next;
    logic [10:0] sum_reg;
    logic [10:0] sum_next;
    logic [4:0]  latch_reg;
    logic [4:0]  latch_next;
    logic [7:0]  store_reg [mcfr_pkg::FRAME_LEN];

    logic [7:0]  view [mcfr_pkg::FRAME_LEN];
    logic [3:0]  count_inc;
    logic [10:0] sum_inc;
    logic [2:0]  status;
    logic [4:0]  faults;
    logic [7:0]  st_byte;
    logic [7:0]  ec_byte;

    // stored bytes with the byte in hand merged at its slot
    always_comb
    begin
        for (int i = 0; i < mcfr_pkg::FRAME_LEN; i++)
        begin
            view[i] = (count_reg == 4'(i)) ? item.rx_byte : store_reg[i];
        end
    end

    assign count_inc = (count_reg < mcfr_pkg::COUNT_SAT) ? count_reg + 4'd1 : count_reg;
    assign sum_inc   = (count_reg >= mcfr_pkg::SUM_FIRST && count_reg <= mcfr_pkg::SUM_LAST)
                     ? sum_reg + {3'b000, item.rx_byte} : sum_reg;

    always_comb
    begin
        if (count_inc != mcfr_pkg::LEN_FULL)
        begin
            status = mcfr_pkg::ST_BAD_LEN;
        end
        else if (view[0] != mcfr_pkg::HDR0 || view[1] != mcfr_pkg::HDR1 ||
                 view[11] != mcfr_pkg::TRL0 || view[12] != mcfr_pkg::TRL1)
        begin
            status = mcfr_pkg::ST_BAD_WRAP;
        end
        else if (sum_inc[7:0] != view[9] || {5'b00000, sum_inc[10:8]} != view[10])
        begin
            status = mcfr_pkg::ST_BAD_SUM;
        end
        else if (view[5] != expected_echo)
        begin
            status = mcfr_pkg::ST_BAD_ECHO;
        end
        else
        begin
            status = mcfr_pkg::ST_OK;
        end
    end

    assign st_byte = view[4];
    assign ec_byte = view[5];
    assign faults  = st_byte[6:2];

    // failed frames carry the status code only
    always_comb
    begin
        result              = '0;
        result.frame_status = status;
        if (status == mcfr_pkg::ST_OK)
        begin
            result.brake_on         = st_byte[0];
            result.motor_running    = st_byte[1];
            result.fault_flags      = faults;
            result.ecu_enabled      = ec_byte[0];
            result.motor_locked     = ec_byte[1];
            result.speed_limit_step = ec_byte[5:3];
            result.assist_mode      = ec_byte[7:6];
            result.hall_changes     = {view[6], view[7]};
            result.alarms_raised    = faults & ~latch_reg;
            result.alarms_cleared   = latch_reg & ~faults;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        latch_next = latch_reg;
        if (step)
        begin
            if (item.frame_end)
            begin
                count_next = '0;
                sum_next   = '0;
                if (status == mcfr_pkg::ST_OK)
                begin
                    latch_next = faults;
                end
            end
            else
            begin
                count_next = count_inc;
                sum_next   = sum_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            latch_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
            latch_reg <= latch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && count_reg < mcfr_pkg::LEN_FULL)
        begin
            store_reg[count_reg] <= item.rx_byte;
        end
    end

endmodule
